@@ design/dtfp_pkg.sv @@
`default_nettype none
package dtfp_pkg;

    localparam int MAX_INT_DIGITS_DEF = 12;
    localparam int FRAC_DIGITS_DEF    = 6;

    localparam int CHAR_W   = 8;
    localparam int OFFSET_W = 41;
    localparam int VALUE_W  = 61;
    localparam int STATUS_W = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic REG_RESULT_OFFSET = 1'b0;

    localparam logic signed [OFFSET_W-1:0] RESULT_OFFSET_RESET = -41'sd123456000;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FORMAT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_line;
    } char_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } result_item_t;

    typedef struct packed {
        logic                negative;
        logic [STATUS_W-1:0] status;
    } snap_ctrl_t;

    function automatic logic [63:0] pow10_const(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic logic [19:0] pow10_small(input logic [2:0] n);
        logic [19:0] w;
        case (n)
            3'd0: w = 20'd1;
            3'd1: w = 20'd10;
            3'd2: w = 20'd100;
            3'd3: w = 20'd1000;
            3'd4: w = 20'd10000;
            3'd5: w = 20'd100000;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ design/dtfp_cfg_regs.sv @@
`default_nettype none
module dtfp_cfg_regs
    import dtfp_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_W-1:0]      paddr,
    input  wire logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]           prdata,
    output logic                            pready,
    output logic signed [OFFSET_W-1:0]      result_offset
);

    logic signed [OFFSET_W-1:0] offset_reg;
    logic signed [OFFSET_W-1:0] offset_next;
    logic                       wr_offset;

    assign pready    = 1'b1;
    assign wr_offset = psel && penable && pwrite && (paddr[3] == REG_RESULT_OFFSET);

    always_comb begin
        offset_next = offset_reg;
        if (wr_offset) begin
            offset_next = pwdata[OFFSET_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= RESULT_OFFSET_RESET;
        end else begin
            offset_reg <= offset_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3] == REG_RESULT_OFFSET) begin
            prdata = {{(APB_DATA_W-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
        end
    end

    assign result_offset = offset_reg;

endmodule
`default_nettype wire

@@ design/dtfp_char_parse.sv @@
`default_nettype none
module dtfp_char_parse
    import dtfp_pkg::*;
#(
    parameter int MAX_INT_DIGITS = MAX_INT_DIGITS_DEF,
    parameter int FRAC_DIGITS    = FRAC_DIGITS_DEF,
    parameter int MAG_W          = $clog2(pow10_const(MAX_INT_DIGITS + FRAC_DIGITS))
)
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire char_item_t        s_data,
    output logic                   snap_valid,
    input  wire logic              snap_ready,
    output snap_ctrl_t             snap_ctrl,
    output logic [MAG_W-1:0]       snap_mag
);

    localparam int IC_W = $clog2(MAX_INT_DIGITS + 2);
    localparam int FC_W = $clog2(FRAC_DIGITS + 1);
    localparam logic [IC_W-1:0]  INT_MAX   = IC_W'(MAX_INT_DIGITS);
    localparam logic [IC_W-1:0]  INT_OVF   = IC_W'(MAX_INT_DIGITS + 1);
    localparam logic [FC_W-1:0]  FRAC_MAX  = FC_W'(FRAC_DIGITS);
    localparam logic [MAG_W-1:0] INT_SCALE = MAG_W'(pow10_const(FRAC_DIGITS));
    localparam logic [63:0]      MAG_BOUND = pow10_const(MAX_INT_DIGITS + FRAC_DIGITS);

    logic        in_valid_reg;
    logic        in_valid_next;
    char_item_t  in_data_reg;

    logic             first_pending_reg, first_pending_next;
    logic             negative_reg, negative_next;
    logic             point_seen_reg, point_seen_next;
    logic             format_bad_reg, format_bad_next;
    logic             digit_seen_reg, digit_seen_next;
    logic [IC_W-1:0]  int_cnt_reg, int_cnt_next;
    logic [FC_W-1:0]  frac_cnt_reg, frac_cnt_next;
    logic [MAG_W-1:0] mag_reg, mag_next;

    logic             line_negative, line_point_seen, line_prev_point;
    logic             line_format_bad, line_digit_seen;
    logic [IC_W-1:0]  line_int_cnt;
    logic [FC_W-1:0]  line_frac_cnt;
    logic [MAG_W-1:0] line_mag;

    logic             snap_valid_reg, snap_valid_next;
    snap_ctrl_t       snap_ctrl_reg;
    logic [MAG_W-1:0] snap_mag_reg;

    logic             snap_take;
    logic             a_move;
    logic             line_done;
    logic [7:0]       ch;
    logic [3:0]       digit;
    logic [2:0]       frac_idx;
    logic [23:0]      frac_prod;
    logic [MAG_W-1:0] mag_times_ten;
    logic [MAG_W-1:0] int_term;
    logic [STATUS_W-1:0] line_status;

    assign snap_take = !snap_valid_reg || snap_ready;
    assign a_move    = in_valid_reg && (!in_data_reg.end_of_line || snap_take);
    assign line_done = a_move && in_data_reg.end_of_line;
    assign s_ready   = !in_valid_reg || a_move;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    assign ch            = in_data_reg.character;
    assign digit         = 4'(ch - CHAR_ZERO);
    assign frac_idx      = 3'(FRAC_DIGITS - 1) - 3'(frac_cnt_reg);
    assign frac_prod     = 24'(digit) * 24'(pow10_small(frac_idx));
    assign mag_times_ten = (mag_reg << 3) + (mag_reg << 1);
    assign int_term      = MAG_W'(digit) * INT_SCALE;

    always_comb begin
        line_negative   = negative_reg;
        line_point_seen = point_seen_reg;
        line_prev_point = 1'b0;
        line_format_bad = format_bad_reg;
        line_digit_seen = digit_seen_reg;
        line_int_cnt    = int_cnt_reg;
        line_frac_cnt   = frac_cnt_reg;
        line_mag        = mag_reg;
        if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
            line_digit_seen = 1'b1;
            if (point_seen_reg) begin
                if (frac_cnt_reg < FRAC_MAX) begin
                    line_mag      = mag_reg + MAG_W'(frac_prod);
                    line_frac_cnt = frac_cnt_reg + FC_W'(1);
                end
            end else if ((int_cnt_reg <= INT_MAX) && ((mag_reg != '0) || (digit != 4'd0))) begin
                if (int_cnt_reg == INT_MAX) begin
                    line_int_cnt = INT_OVF;
                end else begin
                    line_mag     = mag_times_ten + int_term;
                    line_int_cnt = int_cnt_reg + IC_W'(1);
                end
            end
        end else if (ch == CHAR_POINT) begin
            line_format_bad = format_bad_reg || point_seen_reg;
            line_point_seen = 1'b1;
            line_prev_point = 1'b1;
        end else if ((ch == CHAR_PLUS) || (ch == CHAR_MINUS)) begin
            if (first_pending_reg) begin
                line_negative = (ch == CHAR_MINUS);
            end else begin
                line_format_bad = 1'b1;
            end
        end else begin
            line_format_bad = 1'b1;
        end
    end

    always_comb begin
        if (line_format_bad || line_prev_point || !line_digit_seen) begin
            line_status = STATUS_FORMAT;
        end else if (line_int_cnt > INT_MAX) begin
            line_status = STATUS_OVERFLOW;
        end else begin
            line_status = STATUS_OK;
        end
    end

    always_comb begin
        first_pending_next = first_pending_reg;
        negative_next      = negative_reg;
        point_seen_next    = point_seen_reg;
        format_bad_next    = format_bad_reg;
        digit_seen_next    = digit_seen_reg;
        int_cnt_next       = int_cnt_reg;
        frac_cnt_next      = frac_cnt_reg;
        mag_next           = mag_reg;
        if (line_done) begin
            first_pending_next = 1'b1;
            negative_next      = 1'b0;
            point_seen_next    = 1'b0;
            format_bad_next    = 1'b0;
            digit_seen_next    = 1'b0;
            int_cnt_next       = '0;
            frac_cnt_next      = '0;
            mag_next           = '0;
        end else if (a_move) begin
            first_pending_next = 1'b0;
            negative_next      = line_negative;
            point_seen_next    = line_point_seen;
            format_bad_next    = line_format_bad;
            digit_seen_next    = line_digit_seen;
            int_cnt_next       = line_int_cnt;
            frac_cnt_next      = line_frac_cnt;
            mag_next           = line_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pending_reg <= 1'b1;
            negative_reg      <= 1'b0;
            point_seen_reg    <= 1'b0;
            format_bad_reg    <= 1'b0;
            digit_seen_reg    <= 1'b0;
            int_cnt_reg       <= '0;
            frac_cnt_reg      <= '0;
            mag_reg           <= '0;
        end else begin
            first_pending_reg <= first_pending_next;
            negative_reg      <= negative_next;
            point_seen_reg    <= point_seen_next;
            format_bad_reg    <= format_bad_next;
            digit_seen_reg    <= digit_seen_next;
            int_cnt_reg       <= int_cnt_next;
            frac_cnt_reg      <= frac_cnt_next;
            mag_reg           <= mag_next;
        end
    end

    always_comb begin
        snap_valid_next = snap_valid_reg;
        if (line_done) begin
            snap_valid_next = 1'b1;
        end else if (snap_ready) begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (line_done) begin
            snap_ctrl_reg.negative <= line_negative;
            snap_ctrl_reg.status   <= line_status;
            snap_mag_reg           <= line_mag;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_ctrl  = snap_ctrl_reg;
    assign snap_mag   = snap_mag_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        line_done |=> first_pending_reg && (mag_reg == '0) && !point_seen_reg
                      && (int_cnt_reg == '0) && (frac_cnt_reg == '0))
        else $error("Line state not cleared after the last character.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (frac_cnt_reg != '0) |-> point_seen_reg)
        else $error("Fraction digits counted before a point.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && (snap_ctrl_reg.status == STATUS_OK)) |->
            (64'(snap_mag_reg) < MAG_BOUND))
        else $error("Magnitude out of range on an ok line.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && !snap_ready) |=> snap_valid_reg)
        else $error("Pending result lost while the output stage was full.");

endmodule
`default_nettype wire

@@ design/dtfp_result.sv @@
`default_nettype none
module dtfp_result
    import dtfp_pkg::*;
#(
    parameter int MAG_W = 60
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   snap_valid,
    output logic                        snap_ready,
    input  wire snap_ctrl_t             snap_ctrl,
    input  wire logic [MAG_W-1:0]       snap_mag,
    input  wire logic signed [OFFSET_W-1:0] result_offset,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output result_item_t                m_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    result_item_t      out_data_reg;
    logic [VALUE_W-1:0] off_ext;
    logic [VALUE_W-1:0] mag_ext;
    logic [VALUE_W-1:0] addend;
    logic [VALUE_W-1:0] sum;

    assign snap_ready = !out_valid_reg || m_ready;

    assign off_ext = {{(VALUE_W-OFFSET_W){result_offset[OFFSET_W-1]}}, result_offset};
    assign mag_ext = {{(VALUE_W-MAG_W){1'b0}}, snap_mag};
    assign addend  = snap_ctrl.negative ? ~mag_ext : mag_ext;
    assign sum     = off_ext + addend + VALUE_W'(snap_ctrl.negative);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (snap_ready) begin
            out_valid_next = snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            out_data_reg.status <= snap_ctrl.status;
            out_data_reg.value  <= (snap_ctrl.status == STATUS_OK) ? sum : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire

@@ design/decimal_text_to_fixed_point.sv @@
// A line's last character passes the input, pending-result and output registers in turn.
// Throughput: one character per cycle unless a full pending-result stage holds an end-of-line
// character; integer digits multiply-by-ten-and-add, fraction digits add, into the magnitude.
// Output back-pressure reaches s_ready combinationally only through the pending-result stage.
// Reset (aresetn low at a clock edge) clears the line state and all valid flags
// and loads result_offset with -123.456 in units of 1e-6.
`default_nettype none
module decimal_text_to_fixed_point
    import dtfp_pkg::*;
#(
    parameter int MAX_INT_DIGITS = MAX_INT_DIGITS_DEF,
    parameter int FRAC_DIGITS    = FRAC_DIGITS_DEF
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire char_item_t             s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output result_item_t                m_data,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int MAG_W = $clog2(pow10_const(MAX_INT_DIGITS + FRAC_DIGITS));

    logic signed [OFFSET_W-1:0] result_offset;
    logic                       snap_valid;
    logic                       snap_ready;
    snap_ctrl_t                 snap_ctrl;
    logic [MAG_W-1:0]           snap_mag;

    dtfp_cfg_regs u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .result_offset (result_offset)
    );

    dtfp_char_parse #(
        .MAX_INT_DIGITS (MAX_INT_DIGITS),
        .FRAC_DIGITS    (FRAC_DIGITS),
        .MAG_W          (MAG_W)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_ctrl  (snap_ctrl),
        .snap_mag   (snap_mag)
    );

    dtfp_result #(
        .MAG_W (MAG_W)
    ) u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .snap_valid    (snap_valid),
        .snap_ready    (snap_ready),
        .snap_ctrl     (snap_ctrl),
        .snap_mag      (snap_mag),
        .result_offset (result_offset),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
`default_nettype wire

@@ sim/tb_decimal_text_to_fixed_point.sv @@
`timescale 1ns / 100ps
module tb_decimal_text_to_fixed_point;
    import dtfp_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_PAD     = 6;
    localparam int PRESSURE_HOLD = 400;
    localparam int DIR_ROWS      = 10;

    localparam logic [APB_ADDR_W-1:0] OFFSET_ADDR = APB_ADDR_W'(8 * REG_RESULT_OFFSET);
    localparam logic [CHAR_W-1:0]     NUL_STANDIN = 8'h7e;
    localparam logic signed [VALUE_W-1:0] RESET_VALUE = VALUE_W'(RESULT_OFFSET_RESET);

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    char_item_t            s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    result_item_t          m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    decimal_text_to_fixed_point dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser state of the line being received.
    logic        ln_first;
    logic        ln_neg;
    logic        ln_point;
    logic        ln_prev_point;
    logic        ln_bad;
    logic        ln_digit;
    logic [3:0]  ln_int_cnt;
    logic [2:0]  ln_frac_cnt;
    logic [39:0] ln_int_acc;
    logic [19:0] ln_frac_acc;
    logic signed [OFFSET_W-1:0] offset_model;

    result_item_t parsed_values[$];
    logic [CHAR_W-1:0] line_buf[$];

    int err_count      = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_trigger   = 0;

    // A tilde in the table stands for a NUL byte.
    string dir_text [DIR_ROWS] = '{
        "0", "-0", "1234567890123", "-", "1.", "..5", "5-", "\377", "~", "-.5"
    };
    bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 0};
    logic signed [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
        RESET_VALUE, RESET_VALUE, '0, '0, '0, '0, '0, '0, '0, '0
    };
    logic [STATUS_W-1:0] dir_status [DIR_ROWS] = '{
        STATUS_OK, STATUS_OK, STATUS_OVERFLOW, STATUS_FORMAT, STATUS_FORMAT,
        STATUS_FORMAT, STATUS_FORMAT, STATUS_FORMAT, STATUS_FORMAT, STATUS_OK
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic void clear_line_model();
        ln_first      = 1'b1;
        ln_neg        = 1'b0;
        ln_point      = 1'b0;
        ln_prev_point = 1'b0;
        ln_bad        = 1'b0;
        ln_digit      = 1'b0;
        ln_int_cnt    = '0;
        ln_frac_cnt   = '0;
        ln_int_acc    = '0;
        ln_frac_acc   = '0;
    endfunction

    function automatic bit parse_char(input char_item_t it, output result_item_t res);
        logic [CHAR_W-1:0] c;
        logic              was_first;
        logic [3:0]        d;
        logic [63:0]       mag;
        logic [63:0]       unit;
        logic [63:0]       scale;
        int                k;
        c = it.character;
        was_first = ln_first;
        ln_first = 1'b0;
        ln_prev_point = 1'b0;
        res = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = 4'(c - CHAR_ZERO);
            ln_digit = 1'b1;
            if (ln_point) begin
                if (ln_frac_cnt < FRAC_DIGITS_DEF) begin
                    ln_frac_acc = ln_frac_acc * 20'd10 + 20'(d);
                    ln_frac_cnt++;
                end
            end else if (ln_int_cnt <= MAX_INT_DIGITS_DEF && (ln_int_acc != 0 || d != 0)) begin
                if (ln_int_cnt == MAX_INT_DIGITS_DEF) begin
                    ln_int_cnt = 4'(MAX_INT_DIGITS_DEF + 1);
                end else begin
                    ln_int_acc = ln_int_acc * 40'd10 + 40'(d);
                    ln_int_cnt++;
                end
            end
        end else if (c == CHAR_POINT) begin
            if (ln_point) begin
                ln_bad = 1'b1;
            end
            ln_point = 1'b1;
            ln_prev_point = 1'b1;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            if (was_first) begin
                ln_neg = (c == CHAR_MINUS);
            end else begin
                ln_bad = 1'b1;
            end
        end else begin
            ln_bad = 1'b1;
        end

        if (!it.end_of_line) begin
            return 1'b0;
        end

        if (ln_bad || ln_prev_point || !ln_digit) begin
            res.status = STATUS_FORMAT;
        end else if (ln_int_cnt > MAX_INT_DIGITS_DEF) begin
            res.status = STATUS_OVERFLOW;
        end else begin
            unit = 64'd1;
            for (k = 0; k < FRAC_DIGITS_DEF; k++) begin
                unit = unit * 64'd10;
            end
            scale = 64'd1;
            for (k = int'(ln_frac_cnt); k < FRAC_DIGITS_DEF; k++) begin
                scale = scale * 64'd10;
            end
            mag = 64'(ln_int_acc) * unit + 64'(ln_frac_acc) * scale;
            if (ln_neg) begin
                mag = -mag;
            end
            res.status = STATUS_OK;
            res.value  = VALUE_W'(mag + 64'(offset_model));
        end
        clear_line_model();
        return 1'b1;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic eol,
                             input bit typed, input result_item_t typed_res);
        char_item_t   item;
        result_item_t res;
        item.character   = c;
        item.end_of_line = eol;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (parse_char(item, res)) begin
            if (typed) begin
                res = typed_res;
            end
            parsed_values.push_back(res);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (parsed_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic write_offset(input logic signed [OFFSET_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OFFSET_ADDR;
        pwdata  <= {{(APB_DATA_W-OFFSET_W){v[OFFSET_W-1]}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        offset_model = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[OFFSET_W-1:0] !== v) begin
            report_mismatch($sformatf("offset read back %0h want %0h",
                                      prdata[OFFSET_W-1:0], v));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic build_line();
        int kind;
        int nint;
        int nfrac;
        int pos;
        int k;
        logic [CHAR_W-1:0] junk;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind < 85) begin
            case ($urandom_range(3))
                0: line_buf.push_back(CHAR_PLUS);
                1: line_buf.push_back(CHAR_MINUS);
                default: ;
            endcase
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 3)) line_buf.push_back(CHAR_ZERO);
            end
            if ($urandom_range(19) == 0) begin
                repeat (MAX_INT_DIGITS_DEF) line_buf.push_back(CHAR_NINE);
                line_buf.push_back(CHAR_POINT);
                repeat (FRAC_DIGITS_DEF) line_buf.push_back(CHAR_NINE);
            end else begin
                k = $urandom_range(19);
                nint = (k < 2) ? 0 : (k < 4) ? $urandom_range(13, 15) : $urandom_range(1, 12);
                nfrac = ($urandom_range(9) < 6 || nint == 0) ? $urandom_range(1, 9) : 0;
                repeat (nint) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                if (nfrac > 0) begin
                    line_buf.push_back(CHAR_POINT);
                    repeat (nfrac) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                end
            end
            if (kind >= 70) begin
                pos = $urandom_range(line_buf.size());
                case ($urandom_range(4))
                    0: line_buf.insert(pos, 8'($urandom_range(255)));
                    1: line_buf.insert(pos, CHAR_PLUS);
                    2: line_buf.insert(pos, CHAR_MINUS);
                    3: line_buf.insert(pos, CHAR_POINT);
                    default: line_buf.push_back(CHAR_POINT);
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(4))
                    0, 1: junk = 8'($urandom_range(255));
                    2: junk = CHAR_ZERO + 8'($urandom_range(9));
                    3: junk = CHAR_POINT;
                    default: junk = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
                endcase
                line_buf.push_back(junk);
            end
        end
    endtask

    task automatic run_random(input logic signed [OFFSET_W-1:0] offset, input int send_pct,
                              input int recv_pct, input int n_chars, input bit pressure);
        int sent;
        int k;
        write_offset(offset);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure) begin
            hold_trigger++;
        end
        sent = 0;
        while (sent < n_chars) begin
            build_line();
            for (k = 0; k < line_buf.size(); k++) begin
                send_char(line_buf[k], k == line_buf.size() - 1, 1'b0, '0);
            end
            sent += line_buf.size();
        end
        drain();
    endtask

    initial begin
        result_item_t want;
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (parsed_values.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d status %0d",
                                              m_data.value, m_data.status));
                end else begin
                    want = parsed_values.pop_front();
                    if (m_data.value !== want.value) begin
                        report_mismatch($sformatf("value %0d want %0d",
                                                  m_data.value, want.value));
                    end
                    if (m_data.status !== want.status) begin
                        report_mismatch($sformatf("status %0d want %0d",
                                                  m_data.status, want.status));
                    end
                end
            end
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        string        txt;
        result_item_t typed;
        logic [CHAR_W-1:0] c;
        logic signed [OFFSET_W-1:0] rnd_offset;
        int row;
        int k;
        clear_line_model();
        offset_model = RESULT_OFFSET_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < DIR_ROWS; row++) begin
            txt = dir_text[row];
            typed.value  = dir_value[row];
            typed.status = dir_status[row];
            for (k = 0; k < txt.len(); k++) begin
                c = txt[k];
                if (c == NUL_STANDIN) begin
                    c = 8'h00;
                end
                send_char(c, k == txt.len() - 1, dir_typed[row], typed);
            end
        end
        drain();

        run_random(-41'sd999999999999, 0, 0, 300, 1'b0);
        run_random(41'sd999999999999, 76, 0, 280, 1'b0);
        run_random('0, 0, 76, 280, 1'b0);
        rnd_offset = OFFSET_W'(longint'({$urandom, $urandom} % 64'd1999999999999)
                               - 64'sd999999999999);
        run_random(rnd_offset, 10, 10, 280, 1'b0);
        run_random(RESULT_OFFSET_RESET, 0, 0, 260, 1'b1);

        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
